@@ design/assert_macros.svh @@
// Assertion macros shared by the estimator RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gwte_pkg.sv @@
// Package for the gated wind tilt estimator: widths, codes, beat types.
// No dependencies; used by gwte_core and gated_wind_tilt_estimator.
package gwte_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int FIELD_W  = 16;
    localparam int SF_W     = 16;
    localparam int LIMIT_W  = 15;
    localparam int THR_W    = 16;
    localparam int STATUS_W = 2;

    localparam int ACC_W    = ANGLE_WIDTH + FRAC_BITS;
    localparam int CLAMP_SH = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int MAG_W    = ACC_W - CLAMP_SH;
    localparam int SUM_W    = 2 * MAG_W;
    localparam int SUB_W    = SUM_W + 1;
    localparam int ROOT_W   = MAG_W;
    localparam int LIM_SH   = FRAC_BITS - CLAMP_SH;
    localparam int LIM_W    = LIMIT_W + LIM_SH;
    localparam int K_FRAC   = 32;
    localparam int K_W      = K_FRAC + 1;
    localparam int DVD_W    = LIM_W + K_FRAC;
    localparam int DIFF_W   = ((FIELD_W + FRAC_BITS) > ACC_W ? FIELD_W + FRAC_BITS : ACC_W) + 1;
    localparam int EMA_W    = DIFF_W + 1;
    localparam int MUL_W_A  = (DIFF_W > K_W + 1) ? DIFF_W : K_W + 1;
    localparam int MUL_W    = (MUL_W_A > ACC_W + 1) ? MUL_W_A : ACC_W + 1;
    localparam int PROD_W   = 2 * MUL_W;

    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = K_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam int NUM_REGS  = 5;
    localparam int ADDR_W    = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_SMOOTHING_FACTOR = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WIND_LIMIT       = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_THROTTLE_MIN     = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT      = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_LIMIT      = REG_IDX_W'(4);

    localparam logic [SF_W-1:0]    RST_SMOOTHING_FACTOR = SF_W'(6554);
    localparam logic [LIMIT_W-1:0] RST_WIND_LIMIT       = LIMIT_W'(240);
    localparam logic [THR_W-1:0]   RST_THROTTLE_MIN     = THR_W'(22938);
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT      = LIMIT_W'(154);
    localparam logic [LIMIT_W-1:0] RST_ACCEL_LIMIT      = LIMIT_W'(128);

    localparam logic [STATUS_W-1:0] STATUS_CLEARED = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_HELD    = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_UPDATED = STATUS_W'(2);

    typedef struct packed {
        logic signed [FIELD_W-1:0] pitch_angle;
        logic signed [FIELD_W-1:0] roll_angle;
        logic        [THR_W-1:0]   throttle;
        logic signed [FIELD_W-1:0] hor_speed;
        logic signed [FIELD_W-1:0] hor_accel;
        logic signed [FIELD_W-1:0] ver_speed;
        logic signed [FIELD_W-1:0] ver_accel;
    } gwte_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  wind_pitch;
        logic signed [FIELD_W-1:0]  wind_roll;
        logic        [STATUS_W-1:0] status;
    } gwte_out_t;

    typedef struct packed {
        logic [SF_W-1:0]    smoothing_factor;
        logic [LIMIT_W-1:0] wind_limit;
        logic [THR_W-1:0]   throttle_min;
        logic [LIMIT_W-1:0] speed_limit;
        logic [LIMIT_W-1:0] accel_limit;
    } gwte_cfg_t;

    typedef struct packed {
        logic start;
        logic take;
    } gwte_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } gwte_sts_t;

endpackage

@@ design/gwte_core.sv @@
// Estimator core: sequencer around one shared multiplier and one shared subtractor.
// Depends on gwte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gwte_core (
    input  logic                clk,
    input  logic                rst_n,
    input  gwte_pkg::gwte_cfg_t cfg,
    input  gwte_pkg::gwte_ctl_t ctl,
    input  gwte_pkg::gwte_in_t  item,
    output gwte_pkg::gwte_sts_t sts,
    output gwte_pkg::gwte_out_t res
);
    import gwte_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMA_W,
        ST_EX,
        ST_EY,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_CMP,
        ST_SQRT,
        ST_DIV,
        ST_SC0,
        ST_SC1,
        ST_SC2,
        ST_SC3,
        ST_DONE
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [K_W-1:0]          K_MAX   = K_W'(1) << K_FRAC;

    state_t                     state_reg, state_next;
    logic signed [ACC_W-1:0]    acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0]    acc_y_reg, acc_y_next;
    gwte_in_t                   item_reg, item_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic signed [MUL_W-1:0]    op_a_reg, op_a_next;
    logic signed [MUL_W-1:0]    op_b_reg, op_b_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SUM_W-1:0]           rad_reg, rad_next;
    logic [SUM_W-1:0]           root_reg, root_next;
    logic [SUM_W-1:0]           bit_reg, bit_next;
    logic [ROOT_W-1:0]          rem_reg, rem_next;
    logic [K_W-1:0]             dvd_reg, dvd_next;
    logic [K_W-1:0]             quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    logic signed [DIFF_W-1:0]   diff_x, diff_y, ema_step;
    logic signed [EMA_W-1:0]    ema_x, ema_y;
    logic [ACC_W-1:0]           mag_x, mag_y, scaled;
    logic [MAG_W-1:0]           magc_x, magc_y;
    logic [LIM_W-1:0]           lim_val;
    logic [DVD_W-1:0]           dividend;
    logic [SUM_W-1:0]           root_plus;
    logic [ROOT_W:0]            div_trial;
    logic [SUB_W-1:0]           sub_a, sub_b, sub_diff;
    logic                       sub_ge;
    logic                       low_thr, hover;
    logic [FIELD_W-1:0]         abs_vs, abs_va;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [EMA_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > EMA_W'(ACC_MAX)) begin
            r = ACC_MAX;
        end
        else if (v < EMA_W'(ACC_MIN)) begin
            r = ACC_MIN;
        end
        else begin
            r = ACC_W'(v);
        end
        return r;
    endfunction

    assign diff_x   = (DIFF_W'(item_reg.pitch_angle) <<< FRAC_BITS) - DIFF_W'(acc_x_reg);
    assign diff_y   = (DIFF_W'(item_reg.roll_angle) <<< FRAC_BITS) - DIFF_W'(acc_y_reg);
    assign ema_step = DIFF_W'(prod_reg >>> SF_W);
    assign ema_x    = EMA_W'(acc_x_reg) + EMA_W'(ema_step);
    assign ema_y    = EMA_W'(acc_y_reg) + EMA_W'(ema_step);

    assign mag_x  = acc_x_reg[ACC_W-1] ? ACC_W'(-acc_x_reg) : ACC_W'(acc_x_reg);
    assign mag_y  = acc_y_reg[ACC_W-1] ? ACC_W'(-acc_y_reg) : ACC_W'(acc_y_reg);
    assign magc_x = MAG_W'(mag_x >> CLAMP_SH);
    assign magc_y = MAG_W'(mag_y >> CLAMP_SH);
    assign scaled = prod_reg[K_FRAC +: ACC_W];

    assign lim_val   = LIM_W'(cfg.wind_limit) << LIM_SH;
    assign dividend  = DVD_W'(lim_val) << K_FRAC;
    assign root_plus = root_reg + bit_reg;
    assign div_trial = {rem_reg, dvd_reg[K_W-1]};

    assign abs_vs  = item_reg.ver_speed[FIELD_W-1] ? FIELD_W'(-item_reg.ver_speed)
                                                   : FIELD_W'(item_reg.ver_speed);
    assign abs_va  = item_reg.ver_accel[FIELD_W-1] ? FIELD_W'(-item_reg.ver_accel)
                                                   : FIELD_W'(item_reg.ver_accel);
    assign low_thr = item_reg.throttle < cfg.throttle_min;
    assign hover   = (item_reg.hor_speed < $signed({1'b0, cfg.speed_limit}))
                  && (item_reg.hor_accel < $signed({1'b0, cfg.accel_limit}))
                  && (abs_vs < {1'b0, cfg.speed_limit})
                  && (abs_va < {1'b0, cfg.accel_limit});

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            ST_CMP:
            begin
                sub_a = SUB_W'(prod_reg[SUM_W-1:0]);
                sub_b = SUB_W'(sum_reg);
            end
            ST_SQRT:
            begin
                sub_a = SUB_W'(rad_reg);
                sub_b = SUB_W'(root_plus);
            end
            ST_DIV:
            begin
                sub_a = SUB_W'(div_trial);
                sub_b = SUB_W'(root_reg[ROOT_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign sub_diff = sub_a - sub_b;
    assign sub_ge   = ~sub_diff[SUB_W-1];

    always_comb
    begin
        state_next  = state_reg;
        acc_x_next  = acc_x_reg;
        acc_y_next  = acc_y_reg;
        item_next   = item_reg;
        status_next = status_reg;
        op_a_next   = op_a_reg;
        op_b_next   = op_b_reg;
        sum_next    = sum_reg;
        rad_next    = rad_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    item_next  = item;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (low_thr)
                begin
                    acc_x_next  = '0;
                    acc_y_next  = '0;
                    status_next = STATUS_CLEARED;
                    state_next  = ST_DONE;
                end
                else if (hover)
                begin
                    op_a_next   = MUL_W'(diff_x);
                    op_b_next   = MUL_W'({1'b0, cfg.smoothing_factor});
                    status_next = STATUS_UPDATED;
                    state_next  = ST_EMA_W;
                end
                else
                begin
                    status_next = STATUS_HELD;
                    state_next  = ST_DONE;
                end
            end
            ST_EMA_W:
            begin
                op_a_next  = MUL_W'(diff_y);
                state_next = ST_EX;
            end
            ST_EX:
            begin
                acc_x_next = sat_acc(ema_x);
                state_next = ST_EY;
            end
            ST_EY:
            begin
                acc_y_next = sat_acc(ema_y);
                op_a_next  = MUL_W'(magc_x);
                op_b_next  = MUL_W'(magc_x);
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                op_a_next  = MUL_W'(magc_y);
                op_b_next  = MUL_W'(magc_y);
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                sum_next   = prod_reg[SUM_W-1:0];
                op_a_next  = MUL_W'(lim_val);
                op_b_next  = MUL_W'(lim_val);
                state_next = ST_SQ3;
            end
            ST_SQ3:
            begin
                sum_next   = sum_reg + prod_reg[SUM_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!sub_ge)
                begin
                    rad_next   = sum_reg;
                    root_next  = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                    cnt_next   = CNT_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SQRT:
            begin
                if (sub_ge)
                begin
                    rad_next  = sub_diff[SUM_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = ROOT_W'(dividend[DVD_W-1:K_W]);
                    dvd_next   = dividend[K_W-1:0];
                    quo_next   = '0;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sub_ge)
                begin
                    rem_next = sub_diff[ROOT_W-1:0];
                end
                else
                begin
                    rem_next = div_trial[ROOT_W-1:0];
                end
                quo_next = {quo_reg[K_W-2:0], sub_ge};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SC0;
                end
            end
            ST_SC0:
            begin
                op_a_next  = MUL_W'(mag_x);
                op_b_next  = MUL_W'(quo_reg);
                state_next = ST_SC1;
            end
            ST_SC1:
            begin
                op_a_next  = MUL_W'(mag_y);
                state_next = ST_SC2;
            end
            ST_SC2:
            begin
                acc_x_next = acc_x_reg[ACC_W-1] ? -$signed(scaled) : $signed(scaled);
                state_next = ST_SC3;
            end
            ST_SC3:
            begin
                acc_y_next = acc_y_reg[ACC_W-1] ? -$signed(scaled) : $signed(scaled);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        prod_reg   <= op_a_reg * op_b_reg;
        sum_reg    <= sum_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
    end

    assign sts.idle       = (state_reg == ST_IDLE);
    assign sts.done       = (state_reg == ST_DONE);
    assign res.wind_pitch = FIELD_W'(acc_x_reg >>> FRAC_BITS);
    assign res.wind_roll  = FIELD_W'(acc_y_reg >>> FRAC_BITS);
    assign res.status     = status_reg;

    `ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == ST_DIV,
                root_reg != '0, "divisor is zero during division")
    `ASSERT_IMP(a_quo_range, clk, rst_n, state_reg == ST_SC0,
                quo_reg <= K_MAX, "scale factor above one")
    `ASSERT_IMP(a_clear_zero, clk, rst_n,
                state_reg == ST_DONE && status_reg == STATUS_CLEARED,
                acc_x_reg == '0 && acc_y_reg == '0, "cleared beat with nonzero estimate")

endmodule

@@ design/gated_wind_tilt_estimator.sv @@
// Top level of the gated wind tilt estimator: register port, beat handshakes.
// Depends on gwte_pkg, gwte_core and assert_macros.svh.
//
// A sample beat enters on sample/sample_valid and is taken when sample_stall is low.
// Each sample gives exactly one result beat on result/result_valid; the
// receiver holds it off with result_stall, and the beat is kept in an output
// register, so the core may take the next sample meanwhile.
// A cleared or held estimate goes from the decision state straight to done;
// an update runs the smoothing step and a compare against the limit, and an
// update that is clamped also runs 32 square root steps and 33 division
// steps on the shared subtractor and a rescale. sample_stall stays high while
// the core works on a sample, so a new sample is taken only after the last
// result is loaded. A blocked output register holds the core in its done state.
// Reset clears the estimate to zero and loads default register values.
// Registers are written over the APB port at byte address 4*index; write them
// only while no sample is in flight.
`include "assert_macros.svh"

module gated_wind_tilt_estimator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  gwte_pkg::gwte_in_t            sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output gwte_pkg::gwte_out_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gwte_pkg::ADDR_W-1:0]   paddr,
    input  logic [gwte_pkg::DATA_W-1:0]   pwdata,
    output logic [gwte_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gwte_pkg::*;

    gwte_cfg_t              cfg_reg, cfg_next;
    logic                   result_valid_reg, result_valid_next;
    gwte_out_t              result_reg, result_next;
    gwte_ctl_t              core_ctl;
    gwte_sts_t              core_sts;
    gwte_out_t              core_res;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;
    logic                   load;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SMOOTHING_FACTOR: cfg_next.smoothing_factor = pwdata[SF_W-1:0];
                REG_WIND_LIMIT:       cfg_next.wind_limit       = pwdata[LIMIT_W-1:0];
                REG_THROTTLE_MIN:     cfg_next.throttle_min     = pwdata[THR_W-1:0];
                REG_SPEED_LIMIT:      cfg_next.speed_limit      = pwdata[LIMIT_W-1:0];
                REG_ACCEL_LIMIT:      cfg_next.accel_limit      = pwdata[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SMOOTHING_FACTOR: prdata = DATA_W'(cfg_reg.smoothing_factor);
            REG_WIND_LIMIT:       prdata = DATA_W'(cfg_reg.wind_limit);
            REG_THROTTLE_MIN:     prdata = DATA_W'(cfg_reg.throttle_min);
            REG_SPEED_LIMIT:      prdata = DATA_W'(cfg_reg.speed_limit);
            REG_ACCEL_LIMIT:      prdata = DATA_W'(cfg_reg.accel_limit);
            default:              prdata = '0;
        endcase
    end

    assign load           = core_sts.done && (!result_valid_reg || !result_stall);
    assign core_ctl.start = sample_valid && core_sts.idle;
    assign core_ctl.take  = load;
    assign sample_stall   = !core_sts.idle;

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
            result_next       = core_res;
        end
    end

    gwte_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (core_ctl),
        .item  (sample),
        .sts   (core_sts),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_factor <= RST_SMOOTHING_FACTOR;
            cfg_reg.wind_limit       <= RST_WIND_LIMIT;
            cfg_reg.throttle_min     <= RST_THROTTLE_MIN;
            cfg_reg.speed_limit      <= RST_SPEED_LIMIT;
            cfg_reg.accel_limit      <= RST_ACCEL_LIMIT;
            result_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NXT(a_done_hold, clk, rst_n,
                core_sts.done && result_valid_reg && result_stall,
                core_sts.done, "core left done while output register was blocked")

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for gated_wind_tilt_estimator: drives sample beats and APB writes,
// predicts every result beat and compares it field by field. Depends on gwte_pkg and the RTL.
module testbench;
    import gwte_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    gwte_in_t            sample;
    logic                result_valid;
    logic                result_stall = 1'b0;
    gwte_out_t           result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    gwte_cfg_t               cfg_model;
    logic signed [ACC_W-1:0] wind_x_est;
    logic signed [ACC_W-1:0] wind_y_est;
    gwte_out_t               pending_estimates[$];
    int                      mismatch_count = 0;
    int                      send_gap_pct = 10;
    int                      recv_stall_pct = 49;
    int                      hold_request = 0;
    int                      hold_left = 0;

    gated_wind_tilt_estimator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] remaining);
        bit [63:0] root;
        bit [63:0] probe;
        root = '0;
        probe = 64'd1 << 62;
        while (probe > remaining)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (remaining >= root + probe)
            begin
                remaining = remaining - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [ACC_W-1:0] shrink(longint v, bit [63:0] factor);
        bit [127:0] scaled;
        scaled = ({64'b0, magnitude(v)} * {64'b0, factor}) >> K_FRAC;
        if (v < 0)
            return ACC_W'(-longint'(scaled[63:0]));
        return ACC_W'(scaled[63:0]);
    endfunction

    function automatic logic signed [ACC_W-1:0] ema_step(logic signed [ACC_W-1:0] acc,
                                                          logic signed [FIELD_W-1:0] angle);
        longint ceiling;
        longint target;
        longint moved;
        ceiling = (longint'(1) <<< (ACC_W - 1)) - 1;
        target = longint'(angle) <<< FRAC_BITS;
        moved = longint'(acc) +
                (((target - longint'(acc)) * longint'(cfg_model.smoothing_factor)) >>> SF_W);
        if (moved > ceiling)
            moved = ceiling;
        else if (moved < -ceiling - 1)
            moved = -ceiling - 1;
        return ACC_W'(moved);
    endfunction

    function automatic void clamp_estimate();
        bit [63:0] ax;
        bit [63:0] ay;
        bit [63:0] energy;
        bit [63:0] reach;
        bit [63:0] root;
        bit [63:0] factor;
        ax = magnitude(wind_x_est) >> CLAMP_SH;
        ay = magnitude(wind_y_est) >> CLAMP_SH;
        energy = ax * ax + ay * ay;
        reach = 64'(cfg_model.wind_limit) << LIM_SH;
        if (energy <= reach * reach)
            return;
        root = int_sqrt(energy);
        if (root == 0)
            return;
        factor = (reach << K_FRAC) / root;
        wind_x_est = shrink(wind_x_est, factor);
        wind_y_est = shrink(wind_y_est, factor);
    endfunction

    function automatic gwte_out_t predict_estimate(gwte_in_t s);
        gwte_out_t r;
        int        sl;
        int        al;
        int        vs_mag;
        int        va_mag;
        sl = int'(cfg_model.speed_limit);
        al = int'(cfg_model.accel_limit);
        vs_mag = (s.ver_speed < 0) ? -int'(s.ver_speed) : int'(s.ver_speed);
        va_mag = (s.ver_accel < 0) ? -int'(s.ver_accel) : int'(s.ver_accel);
        if (s.throttle < cfg_model.throttle_min)
        begin
            wind_x_est = '0;
            wind_y_est = '0;
            r.status = STATUS_CLEARED;
        end
        else if (int'(s.hor_speed) < sl && int'(s.hor_accel) < al && vs_mag < sl && va_mag < al)
        begin
            wind_x_est = ema_step(wind_x_est, s.pitch_angle);
            wind_y_est = ema_step(wind_y_est, s.roll_angle);
            clamp_estimate();
            r.status = STATUS_UPDATED;
        end
        else
            r.status = STATUS_HELD;
        r.wind_pitch = FIELD_W'(wind_x_est >>> FRAC_BITS);
        r.wind_roll = FIELD_W'(wind_y_est >>> FRAC_BITS);
        return r;
    endfunction

    function automatic int around_zero(int lim);
        return int'($urandom_range(2 * lim - 2)) - (lim - 1);
    endfunction

    function automatic int below(int lim);
        return int'($urandom_range(lim + 32767)) - 32768;
    endfunction

    function automatic gwte_in_t noise_sample();
        logic [$bits(gwte_in_t)-1:0] raw;
        raw = $bits(gwte_in_t)'({$urandom, $urandom, $urandom, $urandom});
        return raw;
    endfunction

    function automatic gwte_in_t calm_sample(int pitch, int roll);
        gwte_in_t s;
        s = '0;
        s.pitch_angle = FIELD_W'(pitch);
        s.roll_angle = FIELD_W'(roll);
        s.throttle = THR_W'(40000);
        return s;
    endfunction

    function automatic gwte_in_t make_sample();
        gwte_in_t s;
        int       sl;
        int       al;
        int       pick;
        s = noise_sample();
        sl = int'(cfg_model.speed_limit);
        al = int'(cfg_model.accel_limit);
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            if (cfg_model.throttle_min != 0)
                s.throttle = THR_W'($urandom_range(int'(cfg_model.throttle_min) - 1));
        end
        else if (pick < 85 && sl > 0 && al > 0)
        begin
            s.throttle = THR_W'($urandom_range(65535, int'(cfg_model.throttle_min)));
            s.hor_speed = FIELD_W'(($urandom_range(4) == 0) ? below(sl) : around_zero(sl));
            s.hor_accel = FIELD_W'(($urandom_range(4) == 0) ? below(al) : around_zero(al));
            s.ver_speed = FIELD_W'(around_zero(sl));
            s.ver_accel = FIELD_W'(around_zero(al));
            if ($urandom_range(1) == 0)
            begin
                s.pitch_angle = FIELD_W'(around_zero(1024));
                s.roll_angle = FIELD_W'(around_zero(1024));
            end
            if ($urandom_range(9) == 0)
                s.ver_speed = FIELD_W'($urandom_range(1) ? sl : -sl);
        end
        return s;
    endfunction

    task automatic send_sample(input gwte_in_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            sample_valid = 1'b0;
            sample = noise_sample();
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample = item;
        do
            @(posedge clk);
        while (sample_stall);
        pending_estimates.push_back(predict_estimate(item));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SMOOTHING_FACTOR: cfg_model.smoothing_factor = value[SF_W-1:0];
            REG_WIND_LIMIT:       cfg_model.wind_limit = value[LIMIT_W-1:0];
            REG_THROTTLE_MIN:     cfg_model.throttle_min = value[THR_W-1:0];
            REG_SPEED_LIMIT:      cfg_model.speed_limit = value[LIMIT_W-1:0];
            REG_ACCEL_LIMIT:      cfg_model.accel_limit = value[LIMIT_W-1:0];
            default:              ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic read_register(input logic [REG_IDX_W-1:0] idx);
        logic [DATA_W-1:0] want;
        case (idx)
            REG_SMOOTHING_FACTOR: want = DATA_W'(cfg_model.smoothing_factor);
            REG_WIND_LIMIT:       want = DATA_W'(cfg_model.wind_limit);
            REG_THROTTLE_MIN:     want = DATA_W'(cfg_model.throttle_min);
            REG_SPEED_LIMIT:      want = DATA_W'(cfg_model.speed_limit);
            default:              want = DATA_W'(cfg_model.accel_limit);
        endcase
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("prdata[%0d]: expected %0h, got %0h", idx, want, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_registers();
        for (int i = 0; i < NUM_REGS; i++)
            read_register(REG_IDX_W'(i));
    endtask

    task automatic set_config(input logic [DATA_W-1:0] sf, input logic [DATA_W-1:0] wl,
                              input logic [DATA_W-1:0] tm, input logic [DATA_W-1:0] sl,
                              input logic [DATA_W-1:0] al);
        wait_drained();
        write_register(REG_SMOOTHING_FACTOR, ($urandom << SF_W) | sf);
        write_register(REG_WIND_LIMIT, ($urandom << LIMIT_W) | wl);
        write_register(REG_THROTTLE_MIN, ($urandom << THR_W) | tm);
        write_register(REG_SPEED_LIMIT, ($urandom << LIMIT_W) | sl);
        write_register(REG_ACCEL_LIMIT, ($urandom << LIMIT_W) | al);
        check_registers();
    endtask

    task automatic test_register_defaults();
        check_registers();
    endtask

    task automatic test_decision_paths();
        gwte_in_t s;
        send_sample(calm_sample(100, -100));
        send_sample(calm_sample(32767, 32767));
        send_sample(calm_sample(-32768, -32768));
        s = calm_sample(500, 500);
        s.throttle = 0;
        send_sample(s);
        s = calm_sample(-32768, 32767);
        s.throttle = RST_THROTTLE_MIN - 1'b1;
        send_sample(s);
        s.throttle = RST_THROTTLE_MIN;
        send_sample(s);
        s = calm_sample(300, 200);
        s.hor_speed = FIELD_W'(RST_SPEED_LIMIT);
        send_sample(s);
        s.hor_speed = -32768;
        send_sample(s);
        s = calm_sample(-300, 50);
        s.ver_speed = FIELD_W'(-int'(RST_SPEED_LIMIT));
        send_sample(s);
        s.ver_speed = FIELD_W'(1 - int'(RST_SPEED_LIMIT));
        send_sample(s);
        s = calm_sample(20, -900);
        s.hor_accel = FIELD_W'(RST_ACCEL_LIMIT - 1'b1);
        send_sample(s);
        s.hor_accel = FIELD_W'(RST_ACCEL_LIMIT);
        send_sample(s);
        s = calm_sample(20, -900);
        s.ver_accel = -32768;
        send_sample(s);
        s = '1;
        s.hor_speed = 32767;
        s.hor_accel = 32767;
        s.ver_speed = 32767;
        s.ver_accel = 32767;
        send_sample(s);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        gwte_in_t s;
        set_config(65535, 32767, 0, 32767, 32767);
        s = calm_sample(32767, -32768);
        s.throttle = 0;
        s.hor_speed = 32766;
        s.hor_accel = -32768;
        s.ver_speed = -32766;
        s.ver_accel = 32766;
        send_sample(s);
        send_sample(calm_sample(-32768, 32767));
        set_config(65535, 0, 0, 32767, 32767);
        send_sample(calm_sample(500, -700));
        send_sample(calm_sample(-1, 1));
        set_config(65535, 240, 0, 154, 128);
        send_sample(calm_sample(2000, 100));
        set_config(0, 240, 0, 154, 128);
        send_sample(calm_sample(-2000, 900));
        set_config(6554, 240, 65535, 154, 128);
        s = calm_sample(-700, 700);
        s.throttle = 65534;
        send_sample(s);
        s.throttle = 65535;
        send_sample(s);
        set_config(6554, 240, 22938, 0, 0);
        send_sample(calm_sample(40, 40));
        wait_drained();
    endtask

    task automatic test_unmapped_writes();
        wait_drained();
        for (int i = NUM_REGS; i < 2 ** REG_IDX_W; i++)
            write_register(REG_IDX_W'(i), $urandom);
        check_registers();
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        logic [DATA_W-1:0] sf;
        logic [DATA_W-1:0] wl;
        logic [DATA_W-1:0] tm;
        logic [DATA_W-1:0] sl;
        logic [DATA_W-1:0] al;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (6)
        begin
            sf = ($urandom_range(4) == 0) ? 65535 : $urandom_range(65535);
            wl = ($urandom_range(7) == 0) ? 0 :
                 ($urandom_range(1) ? $urandom_range(800) : $urandom_range(32767));
            tm = ($urandom_range(7) == 0) ? 65535 : $urandom_range(45000);
            sl = ($urandom_range(7) == 0) ? 32767 : $urandom_range(600, 1);
            al = ($urandom_range(7) == 0) ? 32767 : $urandom_range(600, 1);
            set_config(sf, wl, tm, sl, al);
            repeat (105)
                send_sample(make_sample());
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_request = 400;
        repeat (24)
            send_sample(make_sample());
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (5)
        begin
            repeat (3)
                send_sample(make_sample());
            wait_drained();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall = 1'b1;
        end
        else
            result_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        gwte_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_estimates.size() == 0)
            begin
                $error("result beat with no expectation: %0h", result);
                mismatch_count++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (result.wind_pitch !== want.wind_pitch)
                begin
                    $error("wind_pitch: expected %0d, got %0d", want.wind_pitch,
                           result.wind_pitch);
                    mismatch_count++;
                end
                if (result.wind_roll !== want.wind_roll)
                begin
                    $error("wind_roll: expected %0d, got %0d", want.wind_roll, result.wind_roll);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #10000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_model = '{RST_SMOOTHING_FACTOR, RST_WIND_LIMIT, RST_THROTTLE_MIN,
                      RST_SPEED_LIMIT, RST_ACCEL_LIMIT};
        wind_x_est = '0;
        wind_y_est = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_defaults();
        test_decision_paths();
        test_config_extremes();
        test_unmapped_writes();
        test_random_traffic(10, 49);
        test_random_traffic(49, 10);
        test_random_traffic(0, 0);
        test_output_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/gwte_pkg.sv
design/gwte_core.sv
design/gated_wind_tilt_estimator.sv
tb/testbench.sv
